### src/mgpr_pkg.sv
`default_nettype none

package mgpr_pkg;

    localparam int MAX_N   = 64;
    localparam int ADDR_W  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int VALUE_W = 16;
    localparam int SIZE_W  = 7;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(6);

    // One line store entry: the cell above, its value and whether it was reached
    typedef struct packed {
        logic               reach;
        logic [VALUE_W-1:0] value;
    } line_entry_t;

    // Last valid row/column index for a raw size setting (0 acts as 1, saturates at MAX_N)
    function automatic logic [ADDR_W-1:0] last_index(input logic [SIZE_W-1:0] size);
        logic [SIZE_W:0] clamped;
        begin
            if (size == '0)
                clamped = (SIZE_W+1)'(1);
            else if ({1'b0, size} > (SIZE_W+1)'(MAX_N))
                clamped = (SIZE_W+1)'(MAX_N);
            else
                clamped = {1'b0, size};
            last_index = ADDR_W'(clamped - (SIZE_W+1)'(1));
        end
    endfunction

endpackage

`default_nettype wire

### src/mgpr_ram.sv
`default_nettype none

module mgpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/monotone_grid_path_reachability_core.sv
// Result: the grid's last cell passes the compute stage register, then the output register.
// Throughput: one cell per cycle unless the last cell waits on a full, stalled result slot;
//   the single line RAM takes one read (at accept) and one write-back (compute stage) per cell.
// Reset (rst_n low, asynchronous): grid size returns to 6, position to the origin,
//   pipeline and output register empty. The line RAM is not cleared; row 0 ignores its reads.
`default_nettype none

module monotone_grid_path_reachability_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [mgpr_pkg::VALUE_W-1:0]  cell_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               reachable,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mgpr_pkg::SIZE_W-1:0]   grid_size
);

    import mgpr_pkg::*;

    logic [SIZE_W-1:0]  size_reg;
    logic [ADDR_W-1:0]  last_idx;
    logic [ADDR_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0]  row_reg, row_next;

    logic               s1_valid_reg, s1_valid_next;
    logic [VALUE_W-1:0] s1_value_reg;
    logic [ADDR_W-1:0]  s1_col_reg;
    logic               s1_row0_reg;
    logic               s1_last_reg;

    logic [VALUE_W-1:0] left_value_reg, left_value_next;
    logic               left_reach_reg, left_reach_next;

    logic               out_valid_reg, out_valid_next;
    logic               reachable_reg, reachable_next;

    logic               accept;
    logic               cfg_write;
    logic               s1_fire;
    logic               from_up;
    logic               from_left;
    logic               cell_reach;
    line_entry_t        above_entry;
    line_entry_t        wr_entry;

    assign last_idx  = last_index(size_reg);
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    // The compute stage only waits when it holds the grid's last cell and the result slot is stalled
    assign s1_fire  = s1_valid_reg & (~s1_last_reg | ~out_valid_reg | out_ready);
    assign in_ready = ~s1_valid_reg | s1_fire;
    assign accept   = in_valid & in_ready;

    // Same column of the previous row was written back no later than the cycle this read issues
    mgpr_ram #(
        .WIDTH ($bits(line_entry_t)),
        .DEPTH (MAX_N)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_col_reg),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (col_reg),
        .rdata (above_entry)
    );

    always_comb
    begin
        from_up    = ~s1_row0_reg & above_entry.reach & (above_entry.value < s1_value_reg);
        from_left  = (s1_col_reg != '0) & left_reach_reg & (left_value_reg < s1_value_reg);
        cell_reach = (s1_row0_reg & (s1_col_reg == '0)) | from_up | from_left;
        wr_entry.reach = cell_reach;
        wr_entry.value = s1_value_reg;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == last_idx)
            begin
                col_next = '0;
                row_next = (row_reg == last_idx) ? '0 : row_reg + ADDR_W'(1);
            end
            else
            begin
                col_next = col_reg + ADDR_W'(1);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        left_value_next = left_value_reg;
        left_reach_next = left_reach_reg;
        if (cfg_write || (s1_fire && s1_last_reg))
        begin
            left_value_next = '0;
            left_reach_next = 1'b0;
        end
        else if (s1_fire)
        begin
            left_value_next = s1_value_reg;
            left_reach_next = cell_reach;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        reachable_next = reachable_reg;
        if (s1_fire && s1_last_reg)
        begin
            out_valid_next = 1'b1;
            reachable_next = cell_reach;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= SIZE_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            left_value_reg <= '0;
            left_reach_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                size_reg <= grid_size;
            col_reg        <= col_next;
            row_reg        <= row_next;
            s1_valid_reg   <= s1_valid_next;
            left_value_reg <= left_value_next;
            left_reach_reg <= left_reach_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reachable_reg <= reachable_next;
        if (accept)
        begin
            s1_value_reg <= cell_value;
            s1_col_reg   <= col_reg;
            s1_row0_reg  <= (row_reg == '0);
            s1_last_reg  <= (col_reg == last_idx) && (row_reg == last_idx);
        end
    end

    assign out_valid = out_valid_reg;
    assign reachable = reachable_reg;

endmodule

`default_nettype wire

### src/mgpr_checker.sv
`default_nettype none

module mgpr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          reachable
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(reachable))
        else $error("result dropped or changed while stalled");

    // A new result follows a cell transaction through the compute stage and output registers
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a preceding cell");

    // Input only backs up behind a full, stalled result slot
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output side is free");

endmodule

bind monotone_grid_path_reachability_core mgpr_checker u_mgpr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reachable  (reachable)
);

`default_nettype wire
